// File: rtl/core/asort_pkg.sv
// Shared types and constants for the array sorter.
package asort_pkg;

    localparam int DEPTH     = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = Q_PTR_W + 1;

    typedef struct packed {
        logic signed [31:0] value;
        logic               last_in;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               last_out;
        logic               overflow;
    } t_out_word;

    // Classified word handed from front to back.
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
        logic               store;
        logic               ovf;
    } t_task_word;

    typedef enum logic {
        BK_LOAD,
        BK_DRAIN
    } t_back_state;

endpackage

// File: rtl/core/asort_front.sv
// Front end: accepts input words, tracks set fill and classifies store/drop.
module asort_front
    import asort_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_in_word   i_word,
    input  logic       i_q_full,
    output logic       o_full,
    output logic       o_q_push,
    output t_task_word o_q_word
);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_drop, n_drop;
    logic             accept;
    logic             store;

    assign accept = i_push & ~i_q_full;
    assign store  = (r_count != CNT_W'(DEPTH));
    assign o_full = i_q_full;

    // Dropped non-last words never reach the queue.
    assign o_q_push       = accept & (store | i_word.last_in);
    assign o_q_word.value = i_word.value;
    assign o_q_word.last  = i_word.last_in;
    assign o_q_word.store = store;
    assign o_q_word.ovf   = r_drop | ~store;

    always_comb begin
        n_count = r_count;
        n_drop  = r_drop;
        if (accept) begin
            if (i_word.last_in) begin
                n_count = '0;
                n_drop  = 1'b0;
            end else if (store) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_drop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

endmodule

// File: rtl/core/asort_queue.sv
// Short word queue between front and back.
module asort_queue
    import asort_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_task_word i_word,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_task_word o_word
);

    t_task_word         r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_word  = r_slot[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + Q_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - Q_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: rtl/core/asort_back.sv
// Back end: insertion chain that sorts the set, then drains it in order.
module asort_back
    import asort_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_task_word i_q_word,
    output logic       o_q_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output t_out_word  o_word
);

    t_back_state        r_state, n_state;
    logic signed [31:0] r_cell [DEPTH];
    logic signed [31:0] n_cell [DEPTH];
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic               r_ovf;
    logic               r_out_valid;
    t_out_word          r_out;
    logic               out_free;
    logic               take;
    logic               drain_go;
    logic [DEPTH-1:0]   le;

    assign out_free = ~r_out_valid | i_pop;
    assign o_empty  = ~r_out_valid;
    assign o_word   = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_LOAD: begin
                if (!i_q_empty && i_q_word.last) n_state = BK_DRAIN;
            end
            BK_DRAIN: begin
                if (out_free && r_fill == CNT_W'(1)) n_state = BK_LOAD;
            end
            default: n_state = BK_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        take     = 1'b0;
        drain_go = 1'b0;
        case (r_state)
            BK_LOAD:  take     = ~i_q_empty;
            BK_DRAIN: drain_go = out_free;
            default: ;
        endcase
    end

    assign o_q_pop = take;

    // Cells at or below the new value keep their place; the rest shift up.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            le[i] = (CNT_W'(i) < r_fill) && (r_cell[i] <= i_q_word.value);
        end
        for (int i = 0; i < DEPTH; i++) begin
            n_cell[i] = r_cell[i];
        end
        n_fill = r_fill;
        if (take && i_q_word.store) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (le[i]) begin
                    n_cell[i] = r_cell[i];
                end else if (i == 0) begin
                    n_cell[i] = i_q_word.value;
                end else if (le[i-1]) begin
                    n_cell[i] = i_q_word.value;
                end else begin
                    n_cell[i] = r_cell[i-1];
                end
            end
            n_fill = r_fill + CNT_W'(1);
        end else if (drain_go) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_cell[i] = r_cell[i+1];
            end
            n_fill = r_fill - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_cell[i] <= n_cell[i];
        end
        if (drain_go) begin
            r_out.sorted_value <= r_cell[0];
            r_out.last_out     <= (r_fill == CNT_W'(1));
            r_out.overflow     <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_LOAD;
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (take && i_q_word.last) r_ovf <= i_q_word.ovf;
            if (drain_go) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/core/array_sorter.sv
// Top level of the array sorter: front end, word queue and sorting back end.
//
// Sorts sets of up to DEPTH (16) signed 32-bit words into ascending order.
// Words enter through a queue-style port (push/full); the word flagged last_in
// closes the set. The front end counts the set and drops any word past DEPTH,
// which marks every result of that set with overflow. Kept words pass through
// a 4-word queue to the back end, an insertion chain that places one word per
// cycle, so while a set loads the block takes one word every cycle. Once the
// closing word is taken the chain drains, smallest first, one result per
// cycle while the output register is free, into that register read through
// empty/pop; the final result carries last_out. A set thus loads its kept
// words one by one, its closing word taking a load step even when dropped,
// then drains them in the back end; a stalled pop holds the drain. During
// the drain the front end keeps taking words for the next set until the
// queue fills. Equal values come out in no defined order. No clearing pass
// after reset.
module array_sorter
    import asort_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_word  i_data,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_data
);

    logic       q_push, q_pop, q_full, q_empty;
    t_task_word q_in_word, q_out_word;

    asort_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_word   (i_data),
        .i_q_full (q_full),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_word (q_in_word)
    );

    asort_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_word  (q_in_word),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_word  (q_out_word)
    );

    asort_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_word  (q_out_word),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_word    (o_data)
    );

endmodule

// File: sim/array_sorter_checker.sv
// Checker for the array sorter: models each set, then compares every popped word in order.
`timescale 1ns / 100ps

module array_sorter_checker
    import asort_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_full,
    input  t_in_word  i_in,
    input  logic      i_empty,
    input  logic      i_pop,
    input  t_out_word i_out,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int REPORT_MAX = 10;
    localparam int DUE_DEPTH  = 256;

    // current set as the block should hold it
    logic signed [31:0] set_values [DEPTH];
    int                 set_count;
    logic               set_dropped;

    // ring of results still due, oldest at due_head
    t_out_word          due_buf [DUE_DEPTH];
    logic [7:0]         due_head;
    logic [7:0]         due_tail;
    int                 due_count;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        set_count    = 0;
        set_dropped  = 1'b0;
        due_head     = '0;
        due_tail     = '0;
        due_count    = 0;
    end

    // Take one accepted input word; a closing word sorts the set and queues its results.
    task automatic absorb_word(input t_in_word w);
        logic signed [31:0] held;
        int                 j;
        t_out_word          res;
        if (set_count < DEPTH) begin
            set_values[set_count] = w.value;
            set_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (w.last_in) begin
            for (int a = 1; a < set_count; a++) begin
                held = set_values[a];
                j    = a;
                while (j > 0 && set_values[j-1] > held) begin
                    set_values[j] = set_values[j-1];
                    j--;
                end
                set_values[j] = held;
            end
            for (int k = 0; k < set_count; k++) begin
                res.sorted_value = set_values[k];
                res.last_out     = (k == set_count - 1);
                res.overflow     = set_dropped;
                due_buf[due_tail] = res;
                due_tail          = due_tail + 8'd1;
                due_count++;
            end
            set_count   = 0;
            set_dropped = 1'b0;
        end
    endtask

    task automatic note_failure(input string what, input t_out_word want, input t_out_word got);
        if (o_fail_count < REPORT_MAX)
            $display("%s: expected value %0d last %0b ovf %0b, got value %0d last %0b ovf %0b",
                     what, want.sorted_value, want.last_out, want.overflow,
                     got.sorted_value, got.last_out, got.overflow);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            set_count   = 0;
            set_dropped = 1'b0;
            due_head    = '0;
            due_tail    = '0;
            due_count   = 0;
        end else begin
            // pop side first: a word closing a set at this edge cannot be popped at it
            if (i_pop && !i_empty) begin
                if (due_count == 0) begin
                    note_failure("result with nothing due", '0, i_out);
                end else begin
                    want      = due_buf[due_head];
                    due_head  = due_head + 8'd1;
                    due_count--;
                    if (want.sorted_value !== i_out.sorted_value ||
                        want.last_out !== i_out.last_out ||
                        want.overflow !== i_out.overflow)
                        note_failure("mismatch", want, i_out);
                end
            end
            if (i_push && !i_full)
                absorb_word(i_in);
        end
        o_pending = due_count;
    end

endmodule

// File: sim/array_sorter_tb.sv
// Testbench top for the array sorter: clock, reset, word stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module array_sorter_tb;
    import asort_pkg::*;

    localparam int RANDOM_WORDS = 160;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int TAIL_CYCLES  = 40;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_word  i_data  = '0;
    logic      full;
    logic      empty;
    t_out_word o_data;

    int        fail_count;
    int        pending;
    int        cycle_count = 0;

    // receiver stall pattern: one bit per cycle, refreshed once all its bits are used
    logic [7:0] pop_pattern = 8'hFF;
    logic [2:0] pop_phase   = 3'd0;

    always #1 i_clk = ~i_clk;

    array_sorter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data)
    );

    array_sorter_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in         (i_data),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out        (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Hard stop: far beyond the slowest legal run (every word a full set drained
    // against the longest receiver stall).
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("array_sorter_tb NOT OK");
            $finish;
        end
    end

    // Receiver: pop follows the current pattern. Patterns range from always
    // ready to mostly stalled; every pattern pops at least once per pass, so
    // every receiver stall is bounded.
    always @(posedge i_clk) begin
        pop       <= pop_pattern[pop_phase];
        pop_phase <= pop_phase + 3'd1;
        if (pop_phase == 3'd7) begin
            case ($urandom_range(0, 3))
                0: pop_pattern <= 8'hFF;
                1: pop_pattern <= 8'($urandom) | 8'h01;
                2: pop_pattern <= 8'($urandom) | 8'($urandom) | 8'h10;
                default: pop_pattern <= 8'h01;
            endcase
        end
    end

    // Offer one word and hold it until the block takes it. push stays high on
    // return, so back-to-back words never drop push within a time step.
    task automatic send_word(input logic signed [31:0] v, input logic l);
        push   <= 1'b1;
        i_data <= '{value: v, last_in: l};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic idle_for(input int n);
        push <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Wait until every due result has been popped. The first edge lets the
    // checker take in the word accepted at the previous edge; push is low.
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Mix of wide random values, a narrow band to force equal values, and the
    // signed extremes around zero.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 6)) - 32'sd3;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int words_sent;
        int burst_left;
        int set_len;

        words_sent = 0;
        burst_left = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, words back to back.
        // Set of one: the closing word alone, at the top of the range.
        send_word(32'sh7FFF_FFFF, 1'b1);

        // Signed extremes and zero crossings, most negative value twice.
        send_word(32'sd0, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sd1, 1'b0);
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh8000_0000, 1'b1);

        // Store full: sixteen kept words in descending order so every insertion
        // walks the whole chain, then a dropped word and a dropped closing word.
        for (int i = 0; i < DEPTH; i++)
            send_word(32'sd50000 - 32'(i) * 32'sd7001, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
        send_word(32'sh7FFF_FFFF, 1'b1);

        // Hold off until the sorter has handed back everything so far.
        drain_results();

        // Random part: sets of random length, mostly within capacity, some
        // exactly full, some overflowing. Bursts of random length with gaps.
        while (words_sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: set_len = $urandom_range(1, 8);
                6, 7:             set_len = $urandom_range(9, DEPTH);
                8:                set_len = DEPTH;
                default:          set_len = $urandom_range(DEPTH + 1, DEPTH + 4);
            endcase
            for (int i = 0; i < set_len; i++) begin
                if (burst_left == 0) begin
                    if ($urandom_range(0, 3) != 0)
                        idle_for($urandom_range(1, 6));
                    burst_left = $urandom_range(1, 24);
                end
                send_word(pick_value(), i == set_len - 1);
                burst_left--;
                words_sent++;
            end
        end

        // Let the last set drain, then give the block time to show any stray word.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("array_sorter_tb OK");
        end else begin
            $display("array_sorter_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/asort_pkg.sv
rtl/core/asort_front.sv
rtl/core/asort_queue.sv
rtl/core/asort_back.sv
rtl/core/array_sorter.sv
sim/array_sorter_checker.sv
sim/array_sorter_tb.sv
